FILE: sv/rma_pkg.sv
// Types and constants shared by the rectangle motion animator.
package rma_pkg;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_START  = 3'd1;
  localparam logic [2:0] FUNC_STARTC = 3'd2;
  localparam logic [2:0] FUNC_STOP   = 3'd3;
  localparam logic [2:0] FUNC_FINISH = 3'd4;

  localparam logic [0:0] CFG_ANIM_ENABLE = 1'd0;
  localparam logic [0:0] CFG_BASE_DUR    = 1'd1;

  localparam int DUR_W        = 11;
  localparam int CENTER_EXTRA = 50;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
  } rect_t;

  typedef struct packed {
    logic [31:0]      window;
    logic [47:0]      t_begin;
    logic [DUR_W-1:0] duration;
    logic             curve;
    rect_t            from_rect;
    rect_t            to_rect;
  } entry_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [31:0]        window_id;
    logic [47:0]        now_ms;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic [15:0]        from_w;
    logic [15:0]        from_h;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic [15:0]        to_w;
    logic [15:0]        to_h;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        out_window;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [15:0]        out_w;
    logic [15:0]        out_h;
    logic               finished;
    logic               last;
  } out_word_t;

endpackage

FILE: sv/rma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/rect_motion_animator.sv
// Rectangle motion animator: entry table in RAM, scan, divide, ease and lerp sequencer.
// A recorded start or a stop scans every stored entry, and the start then adds a shift pass
// over the kept entries before it inserts at the head; a tick sends each animating entry
// through the 16-step divider, ease and lerp stages and a finished one straight to output;
// output stalls hold the sequencer. One word at a time.
// Reset: table empty, animations disabled, duration zero; no clearing pass.
module rect_motion_animator #(
  parameter int MAX_ENTRIES  = 64,
  parameter int MIN_DELTA    = 3,
  parameter int MAX_DURATION = 1000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rma_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rma_pkg::out_word_t out_data,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [9:0]        cfg_wdata
);

  localparam int IDX_W = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W = $bits(rma_pkg::entry_t);
  localparam int DW    = rma_pkg::DUR_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DISP  = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_CHK   = 4'd3;
  localparam logic [3:0] ST_TCMP  = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_E1    = 4'd6;
  localparam logic [3:0] ST_E2    = 4'd7;
  localparam logic [3:0] ST_E3    = 4'd8;
  localparam logic [3:0] ST_LERP  = 4'd9;
  localparam logic [3:0] ST_RND   = 4'd10;
  localparam logic [3:0] ST_EMIT  = 4'd11;
  localparam logic [3:0] ST_SH_RD = 4'd12;
  localparam logic [3:0] ST_SH_WR = 4'd13;
  localparam logic [3:0] ST_INS   = 4'd14;

  logic [3:0]          state_r;
  rma_pkg::in_word_t   cur_r;
  logic                en_r;
  logic [9:0]          base_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    rd_idx_r;
  logic [CNT_W-1:0]    wr_idx_r;
  logic [DW-1:0]       dur_r;
  logic [47:0]         diff_r;
  logic                lt_r;
  logic [11:0]         rem_r;
  logic [15:0]         q_r;
  logic [3:0]          step_r;
  logic [31:0]         sq_r;
  logic [63:0]         prod_r;
  logic [16:0]         e_r;
  logic signed [36:0]  n_r [4];
  logic [31:0]         res_win_r;
  rma_pkg::rect_t      res_rect_r;
  logic                res_fin_r;
  logic                res_last_r;
  logic                keep_r;
  logic                imm_r;
  logic                out_valid_r;
  rma_pkg::out_word_t  out_data_r;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  rma_pkg::entry_t     ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENT_W-1:0]    ram_q;
  rma_pkg::entry_t     ent;

  assign ent = rma_pkg::entry_t'(ram_q);

  rma_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ENT_W'(ram_wdata)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  logic out_free;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // start decision terms
  logic signed [16:0] dx, dy, dw, dh;
  logic [16:0]        ax, ay, aw, ah;
  logic               small_move;
  logic [DW:0]        dmin, dsel;
  logic               is_start;

  always_comb begin
    dx = 17'(cur_r.to_x) - 17'(cur_r.from_x);
    dy = 17'(cur_r.to_y) - 17'(cur_r.from_y);
    dw = $signed({1'b0, cur_r.to_w}) - $signed({1'b0, cur_r.from_w});
    dh = $signed({1'b0, cur_r.to_h}) - $signed({1'b0, cur_r.from_h});
    ax = dx[16] ? 17'(-dx) : 17'(dx);
    ay = dy[16] ? 17'(-dy) : 17'(dy);
    aw = dw[16] ? 17'(-dw) : 17'(dw);
    ah = dh[16] ? 17'(-dh) : 17'(dh);
    small_move = ax < 17'(MIN_DELTA) && ay < 17'(MIN_DELTA) &&
                 aw < 17'(MIN_DELTA) && ah < 17'(MIN_DELTA);
    dmin = ({2'b0, base_r} > 12'(MAX_DURATION)) ? 12'(MAX_DURATION) : {2'b0, base_r};
    dsel = dmin;
    if (cur_r.func == rma_pkg::FUNC_STARTC &&
        13'(dmin) + 13'(rma_pkg::CENTER_EXTRA) <= 13'(MAX_DURATION)) begin
      dsel = dmin + 12'(rma_pkg::CENTER_EXTRA);
    end
    is_start = cur_r.func == rma_pkg::FUNC_START || cur_r.func == rma_pkg::FUNC_STARTC;
  end

  // divider, ease and lerp datapath terms
  logic [12:0] dv_t;
  logic [15:0] ease_m, ease_sel;
  logic [17:0] ss_k;
  logic [63:0] quart_t;
  logic signed [16:0] la [4];
  logic signed [16:0] lb [4];
  logic signed [17:0] ld [4];
  rma_pkg::rect_t     fr, tr;
  logic               is_match;

  always_comb begin
    dv_t     = {rem_r, 1'b0};
    ease_m   = q_r[15] ? 16'(17'h10000 - {1'b0, q_r}) : q_r;
    ease_sel = ent.curve ? ease_m : q_r;
    ss_k     = 18'd196608 - {1'b0, q_r, 1'b0};
    quart_t  = (prod_r + 64'h1000_0000_0000) >> 45;
    fr       = ent.from_rect;
    tr       = ent.to_rect;
    la[0] = 17'(fr.x);  lb[0] = 17'(tr.x);
    la[1] = 17'(fr.y);  lb[1] = 17'(tr.y);
    la[2] = $signed({1'b0, fr.w}); lb[2] = $signed({1'b0, tr.w});
    la[3] = $signed({1'b0, fr.h}); lb[3] = $signed({1'b0, tr.h});
    for (int k = 0; k < 4; k++) begin
      ld[k] = 18'(lb[k]) - 18'(la[k]);
    end
    is_match = ent.window == cur_r.window_id;
  end

  function automatic logic [15:0] rnd_s(input logic signed [36:0] n);
    logic [36:0] mag;
    logic [36:0] r;
    mag = n[36] ? 37'(-n) : 37'(n);
    r   = (mag + 37'd32768) >> 16;
    if (n[36]) begin
      rnd_s = (r > 37'd32768) ? 16'h8000 : 16'(37'(-r));
    end else begin
      rnd_s = (r > 37'd32767) ? 16'h7FFF : r[15:0];
    end
  endfunction

  function automatic logic [15:0] rnd_u(input logic signed [36:0] n);
    logic [36:0] r;
    r = (37'(n) + 37'd32768) >> 16;
    if (n[36]) begin
      rnd_u = 16'h0;
    end else begin
      rnd_u = (r > 37'd65535) ? 16'hFFFF : r[15:0];
    end
  endfunction

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_idx_r[IDX_W-1:0];
    ram_wdata = ent;
    ram_re    = 1'b0;
    ram_raddr = rd_idx_r[IDX_W-1:0];
    case (state_r)
      ST_RD: begin
        ram_re = rd_idx_r != cnt_r;
      end
      ST_CHK: begin
        ram_we = (cur_r.func == rma_pkg::FUNC_STOP || is_start) && !is_match;
      end
      ST_EMIT: begin
        ram_we = keep_r && out_free;
      end
      ST_SH_RD: begin
        ram_re    = rd_idx_r != '0;
        ram_raddr = IDX_W'(rd_idx_r - CNT_W'(1));
      end
      ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_idx_r[IDX_W-1:0];
      end
      ST_INS: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata.window     = cur_r.window_id;
        ram_wdata.t_begin    = cur_r.now_ms;
        ram_wdata.duration   = dur_r;
        ram_wdata.curve      = cur_r.func == rma_pkg::FUNC_STARTC;
        ram_wdata.from_rect  = {cur_r.from_x, cur_r.from_y, cur_r.from_w, cur_r.from_h};
        ram_wdata.to_rect    = {cur_r.to_x, cur_r.to_y, cur_r.to_w, cur_r.to_h};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      en_r        <= 1'b0;
      base_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rma_pkg::CFG_ANIM_ENABLE: en_r   <= cfg_wdata[0];
          rma_pkg::CFG_BASE_DUR:    base_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_DISP;
          end
        end
        ST_DISP: begin
          rd_idx_r <= '0;
          wr_idx_r <= '0;
          imm_r    <= 1'b0;
          keep_r   <= 1'b0;
          dur_r    <= dsel[DW-1:0];
          case (cur_r.func)
            rma_pkg::FUNC_TICK: begin
              state_r <= (!en_r || cnt_r == '0 || cur_r.now_ms == '0) ? ST_IDLE : ST_RD;
            end
            rma_pkg::FUNC_START, rma_pkg::FUNC_STARTC: begin
              if (!en_r || base_r == '0 || cnt_r >= CNT_W'(MAX_ENTRIES) ||
                  (cur_r.window_id != '0 && small_move)) begin
                res_win_r  <= cur_r.window_id;
                res_rect_r <= {cur_r.to_x, cur_r.to_y, cur_r.to_w, cur_r.to_h};
                res_fin_r  <= 1'b1;
                res_last_r <= 1'b1;
                imm_r      <= 1'b1;
                state_r    <= ST_EMIT;
              end else if (cur_r.window_id == '0) begin
                state_r <= ST_IDLE;
              end else begin
                state_r <= ST_RD;
              end
            end
            rma_pkg::FUNC_STOP: begin
              state_r <= (cur_r.window_id == '0) ? ST_IDLE : ST_RD;
            end
            rma_pkg::FUNC_FINISH: begin
              state_r <= (cnt_r == '0) ? ST_IDLE : ST_RD;
            end
            default: begin
              state_r <= ST_IDLE;
            end
          endcase
        end
        ST_RD: begin
          if (rd_idx_r == cnt_r) begin
            cnt_r <= wr_idx_r;
            if (is_start) begin
              rd_idx_r <= wr_idx_r;
              state_r  <= ST_SH_RD;
            end else begin
              state_r <= ST_IDLE;
            end
          end else begin
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          res_win_r  <= ent.window;
          res_rect_r <= ent.to_rect;
          res_fin_r  <= 1'b1;
          res_last_r <= CNT_W'(rd_idx_r + CNT_W'(1)) == cnt_r;
          keep_r     <= 1'b0;
          diff_r     <= cur_r.now_ms - ent.t_begin;
          lt_r       <= cur_r.now_ms < ent.t_begin;
          case (cur_r.func)
            rma_pkg::FUNC_FINISH: state_r <= ST_EMIT;
            rma_pkg::FUNC_TICK:   state_r <= ST_TCMP;
            default: begin
              if (!is_match) begin
                wr_idx_r <= wr_idx_r + CNT_W'(1);
              end
              rd_idx_r <= rd_idx_r + CNT_W'(1);
              state_r  <= ST_RD;
            end
          endcase
        end
        ST_TCMP: begin
          if (lt_r || ent.duration == '0 || diff_r >= 48'(ent.duration)) begin
            state_r <= ST_EMIT;
          end else begin
            rem_r   <= 12'(diff_r[DW-1:0]);
            q_r     <= '0;
            step_r  <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dv_t >= 13'(ent.duration)) begin
            rem_r <= 12'(dv_t - 13'(ent.duration));
            q_r   <= {q_r[14:0], 1'b1};
          end else begin
            rem_r <= dv_t[11:0];
            q_r   <= {q_r[14:0], 1'b0};
          end
          step_r <= step_r + 4'd1;
          if (step_r == 4'd15) begin
            state_r <= ST_E1;
          end
        end
        ST_E1: begin
          sq_r    <= 32'(ease_sel) * 32'(ease_sel);
          state_r <= ST_E2;
        end
        ST_E2: begin
          prod_r  <= ent.curve ? 64'(sq_r) * 64'(sq_r) : 64'(sq_r) * 64'(ss_k);
          state_r <= ST_E3;
        end
        ST_E3: begin
          if (ent.curve) begin
            e_r <= q_r[15] ? 17'(17'h10000 - 17'(quart_t)) : 17'(quart_t);
          end else begin
            e_r <= 17'((prod_r + 64'h8000_0000) >> 32);
          end
          state_r <= ST_LERP;
        end
        ST_LERP: begin
          for (int k = 0; k < 4; k++) begin
            n_r[k] <= (37'(la[k]) <<< 16) + 37'(ld[k]) * 37'($signed({1'b0, e_r}));
          end
          state_r <= ST_RND;
        end
        ST_RND: begin
          res_rect_r <= {rnd_s(n_r[0]), rnd_s(n_r[1]), rnd_u(n_r[2]), rnd_u(n_r[3])};
          res_fin_r  <= 1'b0;
          keep_r     <= 1'b1;
          state_r    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (keep_r) begin
              wr_idx_r <= wr_idx_r + CNT_W'(1);
            end
            if (imm_r) begin
              state_r <= ST_IDLE;
            end else begin
              rd_idx_r <= rd_idx_r + CNT_W'(1);
              state_r  <= ST_RD;
            end
          end
        end
        ST_SH_RD: begin
          state_r <= (rd_idx_r == '0) ? ST_INS : ST_SH_WR;
        end
        ST_SH_WR: begin
          rd_idx_r <= rd_idx_r - CNT_W'(1);
          state_r  <= ST_SH_RD;
        end
        ST_INS: begin
          cnt_r   <= cnt_r + CNT_W'(1);
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cur_r <= in_data;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_data_r.out_window <= res_win_r;
      out_data_r.out_x      <= res_rect_r.x;
      out_data_r.out_y      <= res_rect_r.y;
      out_data_r.out_w      <= res_rect_r.w;
      out_data_r.out_h      <= res_rect_r.h;
      out_data_r.finished   <= res_fin_r;
      out_data_r.last       <= res_last_r;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_DISP)
    else $error("accepted word not dispatched");

  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD || state_r == ST_CHK) |-> wr_idx_r <= rd_idx_r)
    else $error("compaction write passed read");

  a_emit_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && keep_r |-> !res_fin_r)
    else $error("kept entry marked finished");

endmodule

FILE: tb/sv/tb_rect_motion_animator.sv
// Self-checking testbench for the rectangle motion animator: directed table, then random words.
`timescale 1ns / 100ps
module tb_rect_motion_animator;

  localparam int N_ENT = 64;
  localparam int N_RAND = 232;
  localparam int PHASE = N_RAND / 4;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [2:0] FUNC_BAD = 3'd6;

  typedef struct {
    logic [31:0]    win;
    logic [47:0]    t0;
    int             dur;
    bit             quartic;
    rma_pkg::rect_t src;
    rma_pkg::rect_t dst;
  } anim_t;

  typedef struct {
    bit                 is_cfg;
    bit                 cidx;
    int                 cval;
    rma_pkg::in_word_t  w;
    bit                 has_exp;
    rma_pkg::out_word_t exp;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  logic [0:0] cfg_index;
  logic [9:0] cfg_wdata;
  rma_pkg::in_word_t in_data;
  rma_pkg::out_word_t out_data;

  anim_t anims[$];
  bit m_enable;
  int m_base;
  rma_pkg::out_word_t geom_q[$];
  int errors;
  int idle_cnt;
  row_t rows[$];
  logic [47:0] clock_ms;

  rect_motion_animator dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned ease_q16(longint unsigned p, bit quartic);
    longint unsigned q;
    if (quartic) begin
      if (p < 32768) return (8 * p * p * p * p + (64'd1 << 47)) >> 48;
      q = 65536 - p;
      return 65536 - ((8 * q * q * q * q + (64'd1 << 47)) >> 48);
    end
    return (p * p * (3 * 65536 - 2 * p) + (64'd1 << 31)) >> 32;
  endfunction

  function automatic logic [15:0] lerp16(int a, int b, longint e, bit sgn);
    longint n, r;
    n = longint'(a) * 65536 + longint'(b - a) * e;
    if (sgn) begin
      r = n >= 0 ? (n + 32768) >>> 16 : -((-n + 32768) >>> 16);
      if (r < -32768) r = -32768;
      if (r > 32767) r = 32767;
    end else begin
      r = n < 0 ? 0 : (n + 32768) >>> 16;
      if (r > 65535) r = 65535;
    end
    return r[15:0];
  endfunction

  function automatic void push_geom(logic [31:0] win, rma_pkg::rect_t r, bit fin);
    rma_pkg::out_word_t o;
    o.out_window = win;
    o.out_x = r.x;
    o.out_y = r.y;
    o.out_w = r.w;
    o.out_h = r.h;
    o.finished = fin;
    o.last = 0;
    geom_q.push_back(o);
  endfunction

  function automatic void drop_window(logic [31:0] win);
    if (win == 0) return;
    for (int i = anims.size() - 1; i >= 0; i--)
      if (anims[i].win == win) anims.delete(i);
  endfunction

  function automatic void predict_word(rma_pkg::in_word_t w);
    int n0, i, dx, dy, dw, dh;
    anim_t a;
    rma_pkg::rect_t dst, src, r;
    longint unsigned el, p, e;
    n0 = geom_q.size();
    dst = '{w.to_x, w.to_y, w.to_w, w.to_h};
    src = '{w.from_x, w.from_y, w.from_w, w.from_h};
    case (w.func)
      rma_pkg::FUNC_START, rma_pkg::FUNC_STARTC: begin
        if (!m_enable || m_base == 0 || anims.size() >= N_ENT) begin
          push_geom(w.window_id, dst, 1);
        end else if (w.window_id != 0) begin
          dx = int'(w.to_x) - int'(w.from_x);
          dy = int'(w.to_y) - int'(w.from_y);
          dw = int'(w.to_w) - int'(w.from_w);
          dh = int'(w.to_h) - int'(w.from_h);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          if (dw < 0) dw = -dw;
          if (dh < 0) dh = -dh;
          if (dx < 3 && dy < 3 && dw < 3 && dh < 3) begin
            push_geom(w.window_id, dst, 1);
          end else begin
            drop_window(w.window_id);
            a.win = w.window_id;
            a.t0 = w.now_ms;
            a.dur = m_base > 1000 ? 1000 : m_base;
            if (w.func == rma_pkg::FUNC_STARTC && a.dur + rma_pkg::CENTER_EXTRA <= 1000)
              a.dur += rma_pkg::CENTER_EXTRA;
            a.quartic = (w.func == rma_pkg::FUNC_STARTC);
            a.src = src;
            a.dst = dst;
            anims.push_front(a);
          end
        end
      end
      rma_pkg::FUNC_STOP: drop_window(w.window_id);
      rma_pkg::FUNC_FINISH: begin
        foreach (anims[k]) push_geom(anims[k].win, anims[k].dst, 1);
        anims.delete();
      end
      rma_pkg::FUNC_TICK: begin
        if (m_enable && w.now_ms != 0) begin
          i = 0;
          while (i < anims.size()) begin
            a = anims[i];
            el = w.now_ms < a.t0 ? a.dur : w.now_ms - a.t0;
            if (a.dur == 0 || el >= a.dur) begin
              push_geom(a.win, a.dst, 1);
              anims.delete(i);
            end else begin
              p = (el << 16) / a.dur;
              e = ease_q16(p, a.quartic);
              r.x = lerp16(int'(a.src.x), int'(a.dst.x), e, 1);
              r.y = lerp16(int'(a.src.y), int'(a.dst.y), e, 1);
              r.w = lerp16(int'(a.src.w), int'(a.dst.w), e, 0);
              r.h = lerp16(int'(a.src.h), int'(a.dst.h), e, 0);
              push_geom(a.win, r, 0);
              i++;
            end
          end
        end
      end
      default: ;
    endcase
    if (geom_q.size() > n0) geom_q[$].last = 1;
  endfunction

  // Check on accepted output words.
  always @(posedge clk) begin
    rma_pkg::out_word_t x;
    if (rst_n && out_valid && !out_stall) begin
      if (geom_q.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, out_data);
        errors++;
      end else begin
        x = geom_q.pop_front();
        if (out_data !== x) begin
          $display("%0t: mismatch, expected %h actual %h", $time, x, out_data);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern.
  always @(posedge clk) begin
    int ph;
    if (!rst_n) begin
      out_stall <= 0;
      ph = 0;
    end else begin
      ph = (ph + 1) % 97;
      if (ph < 30) out_stall <= 0;
      else if (ph < 60) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(rma_pkg::in_word_t w);
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(w);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (geom_q.size() != 0) @(posedge clk);
    in_valid <= 0;
    repeat (200 + 30 * anims.size()) @(posedge clk);
  endtask

  task automatic write_cfg(bit idx, int val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[9:0];
    @(posedge clk);
    cfg_we <= 0;
    if (idx == rma_pkg::CFG_ANIM_ENABLE) m_enable = val[0];
    else m_base = val[9:0];
  endtask

  function automatic rma_pkg::in_word_t mk(logic [2:0] f, logic [31:0] win, logic [47:0] t,
                                           rma_pkg::rect_t s, rma_pkg::rect_t d);
    rma_pkg::in_word_t w;
    w = '{f, win, t, s.x, s.y, s.w, s.h, d.x, d.y, d.w, d.h};
    return w;
  endfunction

  function automatic rma_pkg::rect_t rnd_rect();
    rma_pkg::rect_t r;
    r[31:0] = $urandom;
    r[63:32] = $urandom;
    if ($urandom_range(0, 2) != 0) begin
      r.x = 16'(int'($urandom_range(0, 2000)) - 1000);
      r.y = 16'(int'($urandom_range(0, 2000)) - 1000);
      r.w = 16'($urandom_range(0, 2000));
      r.h = 16'($urandom_range(0, 2000));
    end
    return r;
  endfunction

  function automatic void add_cfg(bit idx, int val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.cidx = idx;
    r.cval = val;
    rows.push_back(r);
  endfunction

  function automatic void add_row(rma_pkg::in_word_t w, bit he, rma_pkg::out_word_t e);
    row_t r;
    r = '{default: '0};
    r.w = w;
    r.has_exp = he;
    r.exp = e;
    rows.push_back(r);
  endfunction

  initial begin
    rma_pkg::rect_t rmin, rmax, ra, rb;
    rma_pkg::in_word_t w;
    rma_pkg::out_word_t e;
    logic [31:0] win;
    int f;
    errors = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    m_enable = 0;
    m_base = 0;
    clock_ms = 1000;
    e = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    rmin = '{-16'sd32768, -16'sd32768, 16'd0, 16'd0};
    rmax = '{16'sd32767, 16'sd32767, 16'hFFFF, 16'hFFFF};
    ra = '{16'sd10, -16'sd20, 16'd100, 16'd50};
    rb = '{-16'sd300, 16'sd400, 16'd900, 16'd5};
    // Disabled after reset: start moves immediately.
    add_row(mk(rma_pkg::FUNC_START, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, rmin, rmax), 1,
            '{32'hFFFFFFFF, rmax.x, rmax.y, rmax.w, rmax.h, 1'b1, 1'b1});
    add_row(mk(rma_pkg::FUNC_TICK, 32'd1, 48'd5, rmin, rmax), 0, e);
    add_cfg(rma_pkg::CFG_ANIM_ENABLE, 1);
    // Duration zero: immediate, even for window zero.
    add_row(mk(rma_pkg::FUNC_STARTC, 32'd0, 48'd1, rmax, rmin), 1,
            '{32'd0, rmin.x, rmin.y, rmin.w, rmin.h, 1'b1, 1'b1});
    add_cfg(rma_pkg::CFG_BASE_DUR, 1000);
    add_row(mk(rma_pkg::FUNC_START, 32'd0, 48'd10, rmin, rmax), 0, e);
    add_row(mk(rma_pkg::FUNC_START, 32'd7, 48'd10, ra, '{ra.x + 16'sd2, ra.y, ra.w, ra.h}), 1,
            '{32'd7, ra.x + 16'sd2, ra.y, ra.w, ra.h, 1'b1, 1'b1});
    add_row(mk(rma_pkg::FUNC_START, 32'd1, 48'd100, rmin, rmax), 0, e);
    add_row(mk(rma_pkg::FUNC_STARTC, 32'd2, 48'd100, rmax, rmin), 0, e);
    add_row(mk(rma_pkg::FUNC_START, 32'd3, 48'd100, ra, rb), 0, e);
    add_row(mk(rma_pkg::FUNC_TICK, 32'd0, 48'd0, ra, rb), 0, e);
    add_row(mk(rma_pkg::FUNC_TICK, 32'd0, 48'd350, ra, rb), 0, e);
    add_row(mk(rma_pkg::FUNC_TICK, 32'd0, 48'd600, ra, rb), 0, e);
    add_row(mk(rma_pkg::FUNC_TICK, 32'd0, 48'd50, ra, rb), 0, e);
    add_row(mk(rma_pkg::FUNC_STARTC, 32'd3, 48'd60, rb, ra), 0, e);
    add_row(mk(rma_pkg::FUNC_STOP, 32'd0, 48'd60, rb, ra), 0, e);
    add_row(mk(rma_pkg::FUNC_STOP, 32'd3, 48'd60, rb, ra), 0, e);
    add_row(mk(FUNC_BAD, 32'd3, 48'd60, rb, ra), 0, e);
    add_row(mk(rma_pkg::FUNC_START, 32'd9, 48'd700, ra, rb), 0, e);
    add_row(mk(rma_pkg::FUNC_TICK, 32'd0, 48'd1200, ra, rb), 0, e);
    add_cfg(rma_pkg::CFG_BASE_DUR, 960);
    add_row(mk(rma_pkg::FUNC_STARTC, 32'd4, 48'd1000, ra, rb), 0, e);
    add_cfg(rma_pkg::CFG_ANIM_ENABLE, 0);
    add_row(mk(rma_pkg::FUNC_TICK, 32'd0, 48'd1100, ra, rb), 0, e);
    add_row(mk(rma_pkg::FUNC_FINISH, 32'd0, 48'd0, ra, rb), 0, e);
    add_row(mk(rma_pkg::FUNC_FINISH, 32'd0, 48'd0, ra, rb), 0, e);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_cfg(rows[i].cidx, rows[i].cval);
      end else begin
        if (rows[i].has_exp) begin
          predict_word(rows[i].w);
          e = geom_q.pop_back();
          if (e !== rows[i].exp) begin
            $display("%0t: table row %0d, expected %h actual %h", $time, i, rows[i].exp, e);
            errors++;
          end
        end
        send_word(rows[i].w);
      end
    end

    // Random phases with several settings.
    for (int n = 0; n < N_RAND; n++) begin
      if (n % PHASE == 0) begin
        write_cfg(rma_pkg::CFG_ANIM_ENABLE, (n != 3 * PHASE));
        case (n / PHASE)
          0: write_cfg(rma_pkg::CFG_BASE_DUR, 1);
          1: write_cfg(rma_pkg::CFG_BASE_DUR, $urandom_range(20, 400));
          2: write_cfg(rma_pkg::CFG_BASE_DUR, 1023);
          default: write_cfg(rma_pkg::CFG_BASE_DUR, 0);
        endcase
      end
      if (n == 2 * PHASE) begin
        // fill the table to exercise the full case
        for (int k = 0; k < N_ENT + 2; k++)
          send_word(mk(rma_pkg::FUNC_START, 32'h100 + k, clock_ms, rmin, rmax));
      end
      f = $urandom_range(0, 99);
      win = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 12);
      if ($urandom_range(0, 30) == 0) win = $urandom;
      if ($urandom_range(0, 5) != 0) clock_ms += 48'($urandom_range(0, 60));
      w = mk(rma_pkg::FUNC_TICK, win, clock_ms, rnd_rect(), rnd_rect());
      if (f < 35) w.func = rma_pkg::FUNC_START;
      else if (f < 50) w.func = rma_pkg::FUNC_STARTC;
      else if (f < 56) w.func = rma_pkg::FUNC_STOP;
      else if (f < 60) w.func = rma_pkg::FUNC_FINISH;
      else if (f < 62) w.func = 3'($urandom_range(5, 7));
      if (w.func == rma_pkg::FUNC_TICK) begin
        if ($urandom_range(0, 15) == 0) w.now_ms = 0;
        else if ($urandom_range(0, 15) == 0)
          w.now_ms = clock_ms - 48'($urandom_range(1, 300));
      end
      if ($urandom_range(0, 40) == 0) w.now_ms = 48'({$urandom, $urandom});
      if ($urandom_range(0, 10) == 0) w.to_x = 16'(w.from_x + 16'sd1);
      send_word(w);
      // burst and gap
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    w = mk(rma_pkg::FUNC_FINISH, 0, 0, rmin, rmax);
    send_word(w);
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
